// ===== src/lruvs_pkg.sv =====
`default_nettype none

package lruvs_pkg;

  localparam int WAYS      = 16;
  localparam int WAY_W     = $clog2(WAYS);
  localparam int MASK_W    = 16;
  localparam int NUM_CORES = 32;
  localparam int CORE_W    = 5;
  localparam int CIDX_W    = $clog2(NUM_CORES);
  localparam int CNT_W     = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_INC,
    ST_RDP,
    ST_DEC,
    ST_RDR,
    ST_RES
  } state_t;

  typedef struct packed {
    logic load;       // capture the accepted transaction
    logic scan_step;  // examine one way for victim selection
    logic pick;       // read chosen way, update ranks and owner
    logic cnt_rd;     // read occupancy count
    logic rd_prev;    // count address is the previous owner (else requester)
    logic cnt_wr;     // write occupancy count
    logic wr_dec;     // decrement previous owner (else increment requester)
    logic out_load;   // load the result register
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic replace;
    logic trk;
    logic dec_prev;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/lru_victim_select_with_owner_count_unit.sv =====
// True-LRU replacement state of one cache set with per-core occupancy counts.
// Input channel (in_*): one transaction per request. in_tuser is the mode,
// 0 = hit update of in_tdata way, 1 = pick and fill a victim among the
// eligible ways. Result channel (out_*): exactly one transaction per request,
// chosen way, its rank before the update, the victim's previous owner and
// the requester's occupancy count after the update.
// cfg_wr_en/cfg_wr_data write the tracking enable (reset value 1); write it
// only while no request is in flight.
// A replace runs the victim scan, which reads one way's rank per cycle; a hit
// skips it. A tracked replace also bumps the requester's count and, when the
// victim had an owner, lowers that owner's count, in the single-port count
// memory, read and written in separate cycles.
// One request is in work at a time; the next is taken as soon as the result
// sits in the output register, even if out_tready is low. A stalled result
// holds; the block waits before loading a new one.
// Reset restores ranks to way index, clears owners and all counts at once.
`default_nettype none

module lru_victim_select_with_owner_count_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [3:0] way, [19:4] eligible_mask, [20] has_requester,
  // [25:21] requester_core, [31:26] zero
  input  wire logic [31:0] in_tdata,
  // [0] mode
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [3:0] chosen_way, [7:4] old_rank, [8] victim_owner_valid,
  // [13:9] victim_owner, [29:14] requester_count, [31:30] zero
  output logic      [31:0] out_tdata,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data
);

  lruvs_pkg::cmd_t cmd;
  lruvs_pkg::sts_t sts;

  logic [lruvs_pkg::WAY_W-1:0]  chosen_way;
  logic [lruvs_pkg::WAY_W-1:0]  old_rank;
  logic                         victim_owner_valid;
  logic [lruvs_pkg::CORE_W-1:0] victim_owner;
  logic [lruvs_pkg::CNT_W-1:0]  requester_count;

  lruvs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_mode    (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd),
    .sts        (sts)
  );

  lruvs_dpath u_dpath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .in_mode                (in_tuser),
    .in_way                 (in_tdata[3:0]),
    .in_eligible_mask       (in_tdata[19:4]),
    .in_has_requester       (in_tdata[20]),
    .in_requester_core      (in_tdata[25:21]),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .out_chosen_way         (chosen_way),
    .out_old_rank           (old_rank),
    .out_victim_owner_valid (victim_owner_valid),
    .out_victim_owner       (victim_owner),
    .out_requester_count    (requester_count)
  );

  assign out_tdata = {2'b00, requester_count, victim_owner, victim_owner_valid,
                      old_rank, chosen_way};

  // one request in work at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in work");

  // a new result only comes from a request in work
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result raised without a request in work");

  a_owner_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[8] |-> out_tdata[13:9] == 5'd0)
    else $error("victim owner reported without a recorded owner");

endmodule

`default_nettype wire

// ===== src/lruvs_ctrl.sv =====
`default_nettype none

module lruvs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  input  wire logic             in_mode,
  output logic                  in_tready,
  input  wire logic             out_tready,
  output logic                  out_tvalid,
  output lruvs_pkg::cmd_t       cmd,
  input  wire lruvs_pkg::sts_t  sts
);

  lruvs_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lruvs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      lruvs_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = in_mode ? lruvs_pkg::ST_SCAN : lruvs_pkg::ST_PICK;
        end
      end
      lruvs_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = lruvs_pkg::ST_PICK;
      end
      lruvs_pkg::ST_PICK: begin
        cmd.pick   = 1'b1;
        cmd.cnt_rd = 1'b1;
        state_nxt  = (sts.replace && sts.trk) ? lruvs_pkg::ST_INC : lruvs_pkg::ST_RES;
      end
      lruvs_pkg::ST_INC: begin
        cmd.cnt_wr = 1'b1;
        state_nxt  = sts.dec_prev ? lruvs_pkg::ST_RDP : lruvs_pkg::ST_RDR;
      end
      lruvs_pkg::ST_RDP: begin
        cmd.cnt_rd  = 1'b1;
        cmd.rd_prev = 1'b1;
        state_nxt   = lruvs_pkg::ST_DEC;
      end
      lruvs_pkg::ST_DEC: begin
        cmd.cnt_wr = 1'b1;
        cmd.wr_dec = 1'b1;
        state_nxt  = lruvs_pkg::ST_RDR;
      end
      lruvs_pkg::ST_RDR: begin
        cmd.cnt_rd = 1'b1;
        state_nxt  = lruvs_pkg::ST_RES;
      end
      lruvs_pkg::ST_RES: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = lruvs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lruvs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ===== src/lruvs_dpath.sv =====
`default_nettype none

module lruvs_dpath (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire lruvs_pkg::cmd_t                      cmd,
  output lruvs_pkg::sts_t                           sts,
  input  wire logic                                 in_mode,
  input  wire logic [lruvs_pkg::WAY_W-1:0]          in_way,
  input  wire logic [lruvs_pkg::MASK_W-1:0]         in_eligible_mask,
  input  wire logic                                 in_has_requester,
  input  wire logic [lruvs_pkg::CORE_W-1:0]         in_requester_core,
  input  wire logic                                 cfg_wr_en,
  input  wire logic                                 cfg_wr_data,
  output logic      [lruvs_pkg::WAY_W-1:0]          out_chosen_way,
  output logic      [lruvs_pkg::WAY_W-1:0]          out_old_rank,
  output logic                                      out_victim_owner_valid,
  output logic      [lruvs_pkg::CORE_W-1:0]         out_victim_owner,
  output logic      [lruvs_pkg::CNT_W-1:0]          out_requester_count
);

  localparam int WAY_W  = lruvs_pkg::WAY_W;
  localparam int CORE_W = lruvs_pkg::CORE_W;
  localparam int CNT_W  = lruvs_pkg::CNT_W;
  localparam int CIDX_W = lruvs_pkg::CIDX_W;
  localparam logic [CORE_W:0]  NCORES    = (CORE_W+1)'(lruvs_pkg::NUM_CORES);
  localparam logic [WAY_W-1:0] LAST_WAY  = WAY_W'(lruvs_pkg::WAYS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  logic                   track_r;
  logic                   mode_r;
  logic [lruvs_pkg::MASK_W-1:0] mask_r;
  logic                   has_req_r;
  logic [CORE_W-1:0]      req_r;
  logic [WAY_W-1:0]       scan_r;
  logic [WAY_W-1:0]       idx_r;
  logic [WAY_W-1:0]       best_r;
  logic [WAY_W-1:0]       old_rank_r;
  logic                   ov_r;
  logic [CORE_W-1:0]      own_r;

  // recency ranks and owners, one entry per way
  logic [WAY_W-1:0]       rank_r     [lruvs_pkg::WAYS];
  logic                   own_vld_r  [lruvs_pkg::WAYS];
  logic [CORE_W-1:0]      own_id_r   [lruvs_pkg::WAYS];

  // occupancy counts; an entry never written reads as zero
  logic [CNT_W-1:0]       cnt_mem    [lruvs_pkg::NUM_CORES];
  logic [lruvs_pkg::NUM_CORES-1:0] cnt_vld_r;
  logic [CNT_W-1:0]       cnt_q_r;
  logic                   cnt_qv_r;

  logic [WAY_W-1:0]       rd_idx;
  logic [WAY_W-1:0]       rank_rd;
  logic                   req_ok;
  logic                   trk;
  logic [CIDX_W-1:0]      cnt_addr;
  logic [CNT_W-1:0]       cnt_cur;
  logic [CNT_W-1:0]       cnt_wdata;

  assign rd_idx   = cmd.pick ? idx_r : scan_r;
  assign rank_rd  = rank_r[rd_idx];
  assign req_ok   = {1'b0, req_r} < NCORES;
  assign trk      = track_r && has_req_r && req_ok;
  assign cnt_addr = cmd.rd_prev || cmd.wr_dec ? own_r[CIDX_W-1:0] : req_r[CIDX_W-1:0];
  assign cnt_cur  = cnt_qv_r ? cnt_q_r : '0;

  always_comb begin
    if (cmd.wr_dec) begin
      cnt_wdata = (cnt_cur == '0) ? '0 : cnt_cur - CNT_W'(1);
    end else begin
      cnt_wdata = (cnt_cur == CNT_MAX) ? CNT_MAX : cnt_cur + CNT_W'(1);
    end
  end

  assign sts.scan_last = (scan_r == LAST_WAY);
  assign sts.replace   = mode_r;
  assign sts.trk       = trk;
  assign sts.dec_prev  = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r <= 1'b1;
    end else if (cfg_wr_en) begin
      track_r <= cfg_wr_data;
    end
  end

  // transaction capture and victim scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= in_mode;
      mask_r    <= in_eligible_mask;
      has_req_r <= in_has_requester;
      req_r     <= in_requester_core;
      scan_r    <= '0;
      best_r    <= '0;
      idx_r     <= in_mode ? '0 : in_way;
    end else if (cmd.scan_step) begin
      // strict compare keeps the lowest index on a tie and skips rank 0
      if (rank_rd > best_r && mask_r[scan_r]) begin
        idx_r  <= scan_r;
        best_r <= rank_rd;
      end
      scan_r <= scan_r + WAY_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      old_rank_r <= rank_rd;
      ov_r       <= mode_r && own_vld_r[idx_r];
      own_r      <= (mode_r && own_vld_r[idx_r]) ? own_id_r[idx_r] : '0;
    end
  end

  // rank and owner update for the chosen way
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < lruvs_pkg::WAYS; w++) begin
        rank_r[w]    <= WAY_W'(w);
        own_vld_r[w] <= 1'b0;
      end
    end else if (cmd.pick) begin
      for (int w = 0; w < lruvs_pkg::WAYS; w++) begin
        if (WAY_W'(w) == idx_r) begin
          rank_r[w] <= '0;
          if (mode_r && trk) own_vld_r[w] <= 1'b1;
        end else if (rank_r[w] < rank_rd) begin
          rank_r[w] <= rank_r[w] + WAY_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick && mode_r && trk) begin
      own_id_r[idx_r] <= req_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_wr) begin
      cnt_mem[cnt_addr] <= cnt_wdata;
    end
    if (cmd.cnt_rd) begin
      cnt_q_r <= cnt_mem[cnt_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
      cnt_qv_r  <= 1'b0;
    end else begin
      if (cmd.cnt_wr) cnt_vld_r[cnt_addr] <= 1'b1;
      if (cmd.cnt_rd) cnt_qv_r <= cnt_vld_r[cnt_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_chosen_way         <= idx_r;
      out_old_rank           <= old_rank_r;
      out_victim_owner_valid <= ov_r;
      out_victim_owner       <= own_r;
      out_requester_count    <= req_ok ? cnt_cur : '0;
    end
  end

endmodule

`default_nettype wire
